### sv/reconnect_backoff_supervisor_defines.svh
// Assertion helpers used by the rbs_engine module.
`ifndef RECONNECT_BACKOFF_SUPERVISOR_DEFINES_SVH
`define RECONNECT_BACKOFF_SUPERVISOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RBS_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RBS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/rbs_pkg.sv
`default_nettype none
package rbs_pkg;

   localparam int DELAY_WIDTH_DEFAULT = 18;
   localparam int CSR_DATA_WIDTH      = 18;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int WAIT_WIDTH          = 18;
   localparam int ATTEMPT_WIDTH       = 8;
   localparam int COUNT_WIDTH         = 16;

   localparam int INITIAL_DELAY_RESET = 1000;
   localparam int MAX_DELAY_RESET     = 30000;
   localparam logic [ATTEMPT_WIDTH-1:0] MAX_ATTEMPTS_RESET = '0;
   localparam logic                     RETRY_ENABLE_RESET = 1'b1;

   localparam logic [ATTEMPT_WIDTH-1:0] ATTEMPT_MAX = '1;
   localparam logic [COUNT_WIDTH-1:0]   COUNT_MAX   = '1;

   typedef enum logic [2:0] {
      FN_CONNECT    = 3'd0,
      FN_OPENED     = 3'd1,
      FN_DROPPED    = 3'd2,
      FN_DISCONNECT = 3'd3,
      FN_TICK       = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      LS_DISCONNECTED = 3'd0,
      LS_CONNECTING   = 3'd1,
      LS_CONNECTED    = 3'd2,
      LS_FAILED       = 3'd3,
      LS_RECONNECTING = 3'd4
   } link_state_type;

   typedef enum logic [1:0] {
      ERR_OK       = 2'd0,
      ERR_ALREADY  = 2'd1,
      ERR_BAD_ADDR = 2'd2
   } err_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_INITIAL_DELAY = 3'd0,
      CSR_MAX_DELAY     = 3'd1,
      CSR_MAX_ATTEMPTS  = 3'd2,
      CSR_RETRY_ENABLE  = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic [ATTEMPT_WIDTH-1:0] max_attempts;
      logic                     retry_enable;
   } cfg_type;

   typedef struct packed {
      link_state_type           link_state;
      logic                     state_changed;
      err_type                  error_code;
      logic                     open_request;
      logic [COUNT_WIDTH-1:0]   reconnect_count;
   } rsp_type;

endpackage
`default_nettype wire

### sv/reconnect_backoff_supervisor.sv
// Reconnect backoff supervisor.
// Request channel (req_valid/req_ready): one event per request, req_func
// selects connect, opened, dropped, disconnect or a one millisecond tick;
// req_url_ok qualifies a connect. Every request yields exactly one response.
// Response channel (rsp_valid/rsp_ready): link state after the event, a
// state change flag, the connect error code, an open request, the retry
// wait scheduled by a drop and the saturating reconnect count.
// Configuration (csr_we/csr_index/csr_wdata): the user is to write it only
// while idle, which the block does not enforce; unknown indexes are dropped.
// A request that is accepted is captured in the input register, evaluated
// against the link state and delivered from the response register. One
// request per cycle is taken while the response register can advance (no
// response held, or rsp_ready high); the engine updates its state per step.
// When rsp_ready is low the response register holds; one more request may
// wait in the input register, and req_ready then drops.
// Reset clears the link state, counters and both valid flags, and restores
// the configuration defaults.
`default_nettype none
module reconnect_backoff_supervisor #(
   parameter int DELAY_WIDTH = rbs_pkg::DELAY_WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [2:0]                          req_func,
   input  wire logic                                req_url_ok,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [2:0]                               rsp_link_state,
   output logic                                     rsp_state_changed,
   output logic [1:0]                               rsp_error_code,
   output logic                                     rsp_open_request,
   output logic [rbs_pkg::WAIT_WIDTH-1:0]           rsp_retry_wait_ms,
   output logic [rbs_pkg::COUNT_WIDTH-1:0]          rsp_reconnect_count,
   input  wire logic                                csr_we,
   input  wire logic [rbs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [rbs_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int WAIT_W = rbs_pkg::WAIT_WIDTH;

   logic                           in_valid_ff, in_valid_in;
   logic [2:0]                     func_ff;
   logic                           url_ok_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   rbs_pkg::rsp_type               rsp_ff;
   logic [WAIT_W-1:0]              wait_ff;

   logic                           advance;
   logic                           step;
   logic [DELAY_WIDTH-1:0]         initial_delay;
   logic [DELAY_WIDTH-1:0]         max_delay;
   rbs_pkg::cfg_type               cfg;
   rbs_pkg::rsp_type               rsp_next;
   logic [DELAY_WIDTH-1:0]         wait_next;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = step ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         func_ff   <= req_func;
         url_ok_ff <= req_url_ok;
      end
      if (step) begin
         rsp_ff  <= rsp_next;
         wait_ff <= WAIT_W'(wait_next);
      end
   end

   rbs_cfg #(
      .DELAY_WIDTH (DELAY_WIDTH)
   ) u_cfg (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .initial_delay (initial_delay),
      .max_delay     (max_delay),
      .cfg           (cfg)
   );

   rbs_engine #(
      .DELAY_WIDTH (DELAY_WIDTH)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .func          (func_ff),
      .url_ok        (url_ok_ff),
      .initial_delay (initial_delay),
      .max_delay     (max_delay),
      .cfg           (cfg),
      .rsp           (rsp_next),
      .wait_ms       (wait_next)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_link_state      = rsp_ff.link_state;
   assign rsp_state_changed   = rsp_ff.state_changed;
   assign rsp_error_code      = rsp_ff.error_code;
   assign rsp_open_request    = rsp_ff.open_request;
   assign rsp_retry_wait_ms   = wait_ff;
   assign rsp_reconnect_count = rsp_ff.reconnect_count;

endmodule
`default_nettype wire

### sv/rbs_cfg.sv
`default_nettype none
module rbs_cfg #(
   parameter int DELAY_WIDTH = rbs_pkg::DELAY_WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [rbs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [rbs_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output logic [DELAY_WIDTH-1:0]                   initial_delay,
   output logic [DELAY_WIDTH-1:0]                   max_delay,
   output rbs_pkg::cfg_type                         cfg
);

   logic [DELAY_WIDTH-1:0] initial_delay_ff;
   logic [DELAY_WIDTH-1:0] max_delay_ff;
   rbs_pkg::cfg_type       cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         initial_delay_ff    <= DELAY_WIDTH'(rbs_pkg::INITIAL_DELAY_RESET);
         max_delay_ff        <= DELAY_WIDTH'(rbs_pkg::MAX_DELAY_RESET);
         cfg_ff.max_attempts <= rbs_pkg::MAX_ATTEMPTS_RESET;
         cfg_ff.retry_enable <= rbs_pkg::RETRY_ENABLE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            rbs_pkg::CSR_INITIAL_DELAY: initial_delay_ff <= DELAY_WIDTH'(csr_wdata);
            rbs_pkg::CSR_MAX_DELAY:     max_delay_ff <= DELAY_WIDTH'(csr_wdata);
            rbs_pkg::CSR_MAX_ATTEMPTS:
               cfg_ff.max_attempts <= csr_wdata[rbs_pkg::ATTEMPT_WIDTH-1:0];
            rbs_pkg::CSR_RETRY_ENABLE:  cfg_ff.retry_enable <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign initial_delay = initial_delay_ff;
   assign max_delay     = max_delay_ff;
   assign cfg           = cfg_ff;

endmodule
`default_nettype wire

### sv/rbs_backoff.sv
`default_nettype none
module rbs_backoff #(
   parameter int DELAY_WIDTH = rbs_pkg::DELAY_WIDTH_DEFAULT
) (
   input  wire logic [DELAY_WIDTH-1:0]             initial_delay,
   input  wire logic [DELAY_WIDTH-1:0]             max_delay,
   input  wire logic [rbs_pkg::ATTEMPT_WIDTH-1:0]  attempt,
   output logic [DELAY_WIDTH-1:0]                  wait_ms
);

   localparam int SHIFT_WIDTH = $clog2(DELAY_WIDTH);

   logic [DELAY_WIDTH-1:0]             first_wait;
   logic [rbs_pkg::ATTEMPT_WIDTH-1:0]  doublings;
   logic [2*DELAY_WIDTH-1:0]           scaled;

   // The wait is min(first_wait * 2^(attempt-1), max_delay). Once the shift
   // reaches the delay width, any nonzero first wait is past the cap.
   always_comb begin
      first_wait = (initial_delay < max_delay) ? initial_delay : max_delay;
      doublings  = (attempt == '0) ? '0 : attempt - 1'b1;
      scaled     = {{DELAY_WIDTH{1'b0}}, first_wait} << doublings[SHIFT_WIDTH-1:0];
      if (first_wait == '0) begin
         wait_ms = '0;
      end else if (doublings >= rbs_pkg::ATTEMPT_WIDTH'(DELAY_WIDTH)) begin
         wait_ms = max_delay;
      end else if (scaled > {{DELAY_WIDTH{1'b0}}, max_delay}) begin
         wait_ms = max_delay;
      end else begin
         wait_ms = scaled[DELAY_WIDTH-1:0];
      end
   end

endmodule
`default_nettype wire

### sv/rbs_engine.sv
`default_nettype none
`include "reconnect_backoff_supervisor_defines.svh"
module rbs_engine #(
   parameter int DELAY_WIDTH = rbs_pkg::DELAY_WIDTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire logic [2:0]              func,
   input  wire logic                    url_ok,
   input  wire logic [DELAY_WIDTH-1:0]  initial_delay,
   input  wire logic [DELAY_WIDTH-1:0]  max_delay,
   input  wire rbs_pkg::cfg_type        cfg,
   output rbs_pkg::rsp_type             rsp,
   output logic [DELAY_WIDTH-1:0]       wait_ms
);

   rbs_pkg::link_state_type            link_state_ff, link_state_in;
   logic                               link_held_ff, link_held_in;
   logic                               wanted_ff, wanted_in;
   logic [rbs_pkg::ATTEMPT_WIDTH-1:0]  attempt_ff, attempt_in;
   logic                               retry_pending_ff, retry_pending_in;
   logic [DELAY_WIDTH-1:0]             retry_remaining_ff, retry_remaining_in;
   logic [rbs_pkg::COUNT_WIDTH-1:0]    reconnect_total_ff, reconnect_total_in;

   rbs_pkg::err_type                   error_code;
   logic                               open_request;
   logic                               retry_allowed;
   logic [rbs_pkg::ATTEMPT_WIDTH-1:0]  attempt_next;
   logic [DELAY_WIDTH-1:0]             backoff_wait;

   assign attempt_next = (attempt_ff == rbs_pkg::ATTEMPT_MAX) ? attempt_ff
                                                              : attempt_ff + 1'b1;
   assign retry_allowed = wanted_ff && cfg.retry_enable &&
                          (cfg.max_attempts == '0 || attempt_ff < cfg.max_attempts);

   rbs_backoff #(
      .DELAY_WIDTH (DELAY_WIDTH)
   ) u_backoff (
      .initial_delay (initial_delay),
      .max_delay     (max_delay),
      .attempt       (attempt_next),
      .wait_ms       (backoff_wait)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         link_state_ff      <= rbs_pkg::LS_DISCONNECTED;
         link_held_ff       <= 1'b0;
         wanted_ff          <= 1'b0;
         attempt_ff         <= '0;
         retry_pending_ff   <= 1'b0;
         retry_remaining_ff <= '0;
         reconnect_total_ff <= '0;
      end else if (step) begin
         link_state_ff      <= link_state_in;
         link_held_ff       <= link_held_in;
         wanted_ff          <= wanted_in;
         attempt_ff         <= attempt_in;
         retry_pending_ff   <= retry_pending_in;
         retry_remaining_ff <= retry_remaining_in;
         reconnect_total_ff <= reconnect_total_in;
      end
   end

   always_comb begin
      link_state_in      = link_state_ff;
      link_held_in       = link_held_ff;
      wanted_in          = wanted_ff;
      attempt_in         = attempt_ff;
      retry_pending_in   = retry_pending_ff;
      retry_remaining_in = retry_remaining_ff;
      reconnect_total_in = reconnect_total_ff;
      error_code         = rbs_pkg::ERR_OK;
      open_request       = 1'b0;
      wait_ms            = '0;
      case (func)
         rbs_pkg::FN_CONNECT: begin
            if (link_held_ff) begin
               error_code = rbs_pkg::ERR_ALREADY;
            end else if (!url_ok) begin
               error_code = rbs_pkg::ERR_BAD_ADDR;
            end else begin
               wanted_in          = 1'b1;
               attempt_in         = '0;
               retry_pending_in   = 1'b0;
               retry_remaining_in = '0;
               link_held_in       = 1'b1;
               link_state_in      = rbs_pkg::LS_CONNECTING;
               open_request       = 1'b1;
            end
         end
         rbs_pkg::FN_OPENED: begin
            if (link_held_ff && link_state_ff == rbs_pkg::LS_CONNECTING) begin
               if (attempt_ff != '0 && reconnect_total_ff != rbs_pkg::COUNT_MAX) begin
                  reconnect_total_in = reconnect_total_ff + 1'b1;
               end
               attempt_in    = '0;
               link_state_in = rbs_pkg::LS_CONNECTED;
            end
         end
         rbs_pkg::FN_DROPPED: begin
            if (link_held_ff && link_state_ff != rbs_pkg::LS_DISCONNECTED) begin
               if (retry_allowed) begin
                  attempt_in         = attempt_next;
                  retry_pending_in   = 1'b1;
                  retry_remaining_in = backoff_wait;
                  wait_ms            = backoff_wait;
                  link_state_in      = rbs_pkg::LS_RECONNECTING;
               end else begin
                  link_state_in = rbs_pkg::LS_FAILED;
               end
            end
         end
         rbs_pkg::FN_DISCONNECT: begin
            wanted_in          = 1'b0;
            retry_pending_in   = 1'b0;
            retry_remaining_in = '0;
            link_held_in       = 1'b0;
            link_state_in      = rbs_pkg::LS_DISCONNECTED;
         end
         rbs_pkg::FN_TICK: begin
            if (retry_pending_ff) begin
               // A countdown of one or zero is due on this tick.
               if (retry_remaining_ff <= DELAY_WIDTH'(1)) begin
                  retry_pending_in   = 1'b0;
                  retry_remaining_in = '0;
                  if (wanted_ff) begin
                     link_held_in  = 1'b1;
                     link_state_in = rbs_pkg::LS_CONNECTING;
                     open_request  = 1'b1;
                  end
               end else begin
                  retry_remaining_in = retry_remaining_ff - 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp.link_state      = link_state_in;
      rsp.state_changed   = (link_state_in != link_state_ff);
      rsp.error_code      = error_code;
      rsp.open_request    = open_request;
      rsp.reconnect_count = reconnect_total_in;
   end

   `RBS_ASSERT_SAME(a_open_goes_connecting, clock, reset, step && open_request,
                    link_state_in == rbs_pkg::LS_CONNECTING,
                    "open request without entering connecting")
   `RBS_ASSERT_SAME(a_error_keeps_state, clock, reset,
                    step && error_code != rbs_pkg::ERR_OK,
                    link_state_in == link_state_ff && !open_request,
                    "rejected connect changed the link")
   `RBS_ASSERT_SAME(a_wait_capped, clock, reset, step && wait_ms != '0,
                    wait_ms <= max_delay && link_state_in == rbs_pkg::LS_RECONNECTING,
                    "scheduled wait above cap or outside a retry")
   `RBS_ASSERT_NEXT(a_total_monotonic, clock, reset, 1'b1,
                    reconnect_total_ff >= $past(reconnect_total_ff),
                    "reconnect count went down")

endmodule
`default_nettype wire

### tb/sv/tb_reconnect_backoff_supervisor.sv
`default_nettype none
module tb_reconnect_backoff_supervisor;
   import rbs_pkg::*;

   localparam int CSR_SPARE_LO   = CSR_RETRY_ENABLE + 1;
   localparam int CSR_SPARE_HI   = (1 << CSR_INDEX_WIDTH) - 1;
   localparam int FN_SPARE_LO    = FN_TICK + 1;
   localparam int FN_SPARE_HI    = (1 << 3) - 1;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [WAIT_WIDTH-1:0] DELAY_MAX = '1;

   typedef struct packed {
      link_state_type            state;
      logic                      changed;
      err_type                   err;
      logic                      open;
      logic [WAIT_WIDTH-1:0]     wait_ms;
      logic [COUNT_WIDTH-1:0]    count;
   } link_report_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [2:0]                 req_func = '0;
   logic                       req_url_ok = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b1;
   logic [2:0]                 rsp_link_state;
   logic                       rsp_state_changed;
   logic [1:0]                 rsp_error_code;
   logic                       rsp_open_request;
   logic [WAIT_WIDTH-1:0]      rsp_retry_wait_ms;
   logic [COUNT_WIDTH-1:0]     rsp_reconnect_count;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // Shadow copy of the supervisor state and its configuration.
   link_state_type            shadow_state = LS_DISCONNECTED;
   logic                      shadow_held = 1'b0;
   logic                      shadow_wanted = 1'b0;
   logic [ATTEMPT_WIDTH-1:0]  shadow_attempts = '0;
   logic [WAIT_WIDTH-1:0]     shadow_delay = '0;
   logic                      shadow_pending = 1'b0;
   logic [WAIT_WIDTH-1:0]     shadow_remaining = '0;
   logic [COUNT_WIDTH-1:0]    shadow_reconnects = '0;
   logic [WAIT_WIDTH-1:0]     cfg_first_ms = WAIT_WIDTH'(INITIAL_DELAY_RESET);
   logic [WAIT_WIDTH-1:0]     cfg_ceiling_ms = WAIT_WIDTH'(MAX_DELAY_RESET);
   logic [ATTEMPT_WIDTH-1:0]  cfg_attempts = MAX_ATTEMPTS_RESET;
   logic                      cfg_retry_on = RETRY_ENABLE_RESET;

   link_report_type pending_reports[$];
   link_report_type head_report;
   int unsigned  fail_count = 0;
   int unsigned  idle_pct = 0;
   int unsigned  stall_left = 0;
   int unsigned  quiet_cycles = 0;

   reconnect_backoff_supervisor uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_url_ok          (req_url_ok),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_link_state      (rsp_link_state),
      .rsp_state_changed   (rsp_state_changed),
      .rsp_error_code      (rsp_error_code),
      .rsp_open_request    (rsp_open_request),
      .rsp_retry_wait_ms   (rsp_retry_wait_ms),
      .rsp_reconnect_count (rsp_reconnect_count),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic logic [WAIT_WIDTH-1:0] backoff_ms(logic [ATTEMPT_WIDTH-1:0] attempt);
      logic [WAIT_WIDTH:0] d;
      logic [WAIT_WIDTH:0] cap;
      cap = {1'b0, cfg_ceiling_ms};
      d = (cfg_first_ms < cfg_ceiling_ms) ? {1'b0, cfg_first_ms} : cap;
      for (int i = 1; i < int'(attempt); i++) begin
         if (d >= cap || d == '0) break;
         d = d << 1;
         if (d > cap) d = cap;
      end
      return d[WAIT_WIDTH-1:0];
   endfunction

   // Applies one accepted request to the shadow state and queues the response it owes.
   task automatic advance_supervisor(logic [2:0] fn, logic url_ok);
      link_report_type rep;
      link_state_type  prior;
      prior = shadow_state;
      rep = '0;
      case (fn)
         FN_CONNECT: begin
            if (shadow_held) begin
               rep.err = ERR_ALREADY;
            end else if (!url_ok) begin
               rep.err = ERR_BAD_ADDR;
            end else begin
               shadow_wanted = 1'b1;
               shadow_attempts = '0;
               shadow_pending = 1'b0;
               shadow_remaining = '0;
               shadow_held = 1'b1;
               shadow_state = LS_CONNECTING;
               rep.open = 1'b1;
            end
         end
         FN_OPENED: begin
            if (shadow_held && shadow_state == LS_CONNECTING) begin
               if (shadow_attempts != 0 && shadow_reconnects != COUNT_MAX)
                  shadow_reconnects++;
               shadow_attempts = '0;
               shadow_state = LS_CONNECTED;
            end
         end
         FN_DROPPED: begin
            if (shadow_held && shadow_state != LS_DISCONNECTED) begin
               if (shadow_wanted && cfg_retry_on &&
                   (cfg_attempts == 0 || shadow_attempts < cfg_attempts)) begin
                  if (shadow_attempts != ATTEMPT_MAX) shadow_attempts++;
                  shadow_delay = backoff_ms(shadow_attempts);
                  shadow_pending = 1'b1;
                  shadow_remaining = shadow_delay;
                  rep.wait_ms = shadow_delay;
                  shadow_state = LS_RECONNECTING;
               end else begin
                  shadow_state = LS_FAILED;
               end
            end
         end
         FN_DISCONNECT: begin
            shadow_wanted = 1'b0;
            shadow_pending = 1'b0;
            shadow_remaining = '0;
            shadow_held = 1'b0;
            shadow_state = LS_DISCONNECTED;
         end
         FN_TICK: begin
            if (shadow_pending) begin
               if (shadow_remaining <= 1) begin
                  shadow_pending = 1'b0;
                  shadow_remaining = '0;
                  if (shadow_wanted) begin
                     shadow_held = 1'b1;
                     shadow_state = LS_CONNECTING;
                     rep.open = 1'b1;
                  end
               end else begin
                  shadow_remaining--;
               end
            end
         end
         default: begin
         end
      endcase
      rep.state = shadow_state;
      rep.changed = (shadow_state != prior);
      rep.count = shadow_reconnects;
      pending_reports.push_back(rep);
   endtask

   task automatic report_mismatch(string what);
      fail_count++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   // The request stays valid from one request to the next unless a gap is drawn.
   task automatic send_event(logic [2:0] fn, logic url_ok);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_func   <= fn;
      req_url_ok <= url_ok;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_supervisor(fn, url_ok);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes all four registers, then one spare index above the last that must be ignored.
   task automatic program_timing(logic [WAIT_WIDTH-1:0] first_ms,
                                 logic [WAIT_WIDTH-1:0] ceiling_ms,
                                 logic [ATTEMPT_WIDTH-1:0] attempts, logic enable);
      logic [CSR_INDEX_WIDTH-1:0] spare;
      drain_responses();
      spare = CSR_INDEX_WIDTH'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI));
      csr_we    <= 1'b1;
      csr_index <= CSR_INITIAL_DELAY;
      csr_wdata <= first_ms;
      @(posedge clock);
      csr_index <= CSR_MAX_DELAY;
      csr_wdata <= ceiling_ms;
      @(posedge clock);
      csr_index <= CSR_MAX_ATTEMPTS;
      csr_wdata <= {(CSR_DATA_WIDTH-ATTEMPT_WIDTH)'($urandom_range(0, 1023)), attempts};
      @(posedge clock);
      csr_index <= CSR_RETRY_ENABLE;
      csr_wdata <= {(CSR_DATA_WIDTH-1)'($urandom), enable};
      @(posedge clock);
      csr_index <= spare;
      csr_wdata <= CSR_DATA_WIDTH'($urandom_range(0, DELAY_MAX));
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_first_ms   = first_ms;
      cfg_ceiling_ms = ceiling_ms;
      cfg_attempts   = attempts;
      cfg_retry_on   = enable;
   endtask

   // Chooses the next event from the shadow state so that sessions run deep,
   // with a share of arbitrary events mixed in.
   task automatic pick_session_event(output logic [2:0] fn, output logic url_ok);
      int unsigned r;
      r = $urandom_range(0, 99);
      url_ok = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 12) begin
         fn = 3'($urandom_range(0, FN_SPARE_HI));
      end else begin
         case (shadow_state)
            LS_DISCONNECTED: begin
               fn = (r < 85) ? FN_CONNECT : 3'($urandom_range(FN_OPENED, FN_TICK));
               if (r < 85) url_ok = ($urandom_range(0, 9) != 0);
            end
            LS_FAILED:
               fn = (r < 60) ? FN_DISCONNECT : (r < 90) ? FN_CONNECT : FN_TICK;
            LS_CONNECTING:
               fn = (r < 70) ? FN_OPENED : (r < 85) ? FN_DROPPED :
                    (r < 95) ? FN_TICK : FN_CONNECT;
            LS_CONNECTED:
               fn = (r < 45) ? FN_TICK : (r < 80) ? FN_DROPPED :
                    (r < 90) ? FN_DISCONNECT : FN_CONNECT;
            default: begin
               if (shadow_remaining <= 64)
                  fn = (r < 85) ? FN_TICK : (r < 93) ? FN_DROPPED : FN_DISCONNECT;
               else
                  fn = (r < 40) ? FN_TICK : (r < 80) ? FN_DROPPED : FN_DISCONNECT;
            end
         endcase
      end
   endtask

   // Nothing written yet: the register defaults set the first waits.
   task automatic test_default_backoff();
      idle_pct = 20;
      send_event(FN_CONNECT, 1'b1);
      send_event(FN_OPENED, 1'b0);
      send_event(FN_DROPPED, 1'b1);
      send_event(FN_DROPPED, 1'b0);
      send_event(FN_TICK, 1'b1);
      send_event(FN_DISCONNECT, 1'b1);
   endtask

   task automatic test_connect_paths();
      program_timing(5, 40, 0, 1'b1);
      send_event(FN_CONNECT, 1'b0);
      send_event(FN_TICK, 1'b0);
      send_event(FN_OPENED, 1'b1);
      send_event(FN_DROPPED, 1'b1);
      for (int fn = FN_SPARE_LO; fn <= FN_SPARE_HI; fn++) send_event(3'(fn), fn[0]);
      send_event(FN_CONNECT, 1'b1);
      send_event(FN_CONNECT, 1'b1);
      send_event(FN_CONNECT, 1'b0);
      send_event(FN_OPENED, 1'b0);
      send_event(FN_OPENED, 1'b1);
      send_event(FN_DISCONNECT, 1'b0);
      send_event(FN_DISCONNECT, 1'b1);
   endtask

   task automatic test_retry_paths();
      // A zero wait fires on the very next tick.
      program_timing(0, 0, 0, 1'b1);
      send_event(FN_CONNECT, 1'b1);
      send_event(FN_DROPPED, 1'b0);
      send_event(FN_TICK, 1'b0);
      send_event(FN_OPENED, 1'b0);
      program_timing(2, 5, 2, 1'b1);
      send_event(FN_DROPPED, 1'b0);
      send_event(FN_TICK, 1'b0);
      send_event(FN_TICK, 1'b0);
      send_event(FN_DROPPED, 1'b0);
      send_event(FN_DROPPED, 1'b1);
      send_event(FN_TICK, 1'b0);
      send_event(FN_CONNECT, 1'b1);
      send_event(FN_DISCONNECT, 1'b0);
      program_timing(3, 10, 0, 1'b0);
      send_event(FN_CONNECT, 1'b1);
      send_event(FN_OPENED, 1'b0);
      send_event(FN_DROPPED, 1'b0);
      send_event(FN_DISCONNECT, 1'b0);
      // A disconnect cancels a scheduled retry.
      program_timing(3, 10, 0, 1'b1);
      send_event(FN_CONNECT, 1'b1);
      send_event(FN_DROPPED, 1'b0);
      send_event(FN_DISCONNECT, 1'b0);
      repeat (4) send_event(FN_TICK, 1'b1);
      send_event(FN_OPENED, 1'b1);
   endtask

   task automatic test_delay_extremes();
      program_timing(DELAY_MAX, DELAY_MAX, 0, 1'b1);
      send_event(FN_CONNECT, 1'b1);
      send_event(FN_DROPPED, 1'b0);
      send_event(FN_DROPPED, 1'b0);
      repeat (3) send_event(FN_TICK, 1'b0);
      send_event(FN_DISCONNECT, 1'b0);
      program_timing(DELAY_MAX, 100, 0, 1'b1);
      send_event(FN_CONNECT, 1'b1);
      send_event(FN_DROPPED, 1'b0);
      send_event(FN_DISCONNECT, 1'b0);
      program_timing(0, DELAY_MAX, 0, 1'b1);
      send_event(FN_CONNECT, 1'b1);
      send_event(FN_DROPPED, 1'b0);
      send_event(FN_DROPPED, 1'b0);
      send_event(FN_TICK, 1'b0);
      send_event(FN_DISCONNECT, 1'b0);
   endtask

   // Repeated drops walk the wait up to the ceiling and the attempt count to its limit.
   task automatic test_attempt_saturation();
      idle_pct = 10;
      program_timing(1, DELAY_MAX, 0, 1'b1);
      send_event(FN_CONNECT, 1'b1);
      repeat (ATTEMPT_MAX + 5) send_event(FN_DROPPED, 1'($urandom_range(0, 1)));
      send_event(FN_DISCONNECT, 1'b0);
      program_timing(1, 1000, ATTEMPT_MAX, 1'b1);
      send_event(FN_CONNECT, 1'b1);
      repeat (ATTEMPT_MAX + 1) send_event(FN_DROPPED, 1'($urandom_range(0, 1)));
      send_event(FN_DISCONNECT, 1'b0);
   endtask

   task automatic test_random_sessions(int unsigned phases, int unsigned per_phase);
      logic [2:0]               fn;
      logic                     url_ok;
      logic [WAIT_WIDTH-1:0]    first_ms;
      logic [WAIT_WIDTH-1:0]    ceiling_ms;
      logic [ATTEMPT_WIDTH-1:0] attempts;
      for (int p = 0; p < phases; p++) begin
         first_ms   = WAIT_WIDTH'(($urandom_range(0, 9) == 0) ?
                                  $urandom_range(0, DELAY_MAX) : $urandom_range(0, 6));
         ceiling_ms = WAIT_WIDTH'(($urandom_range(0, 9) == 0) ?
                                  $urandom_range(0, DELAY_MAX) : $urandom_range(0, 40));
         attempts   = ATTEMPT_WIDTH'(($urandom_range(0, 4) == 0) ?
                                     $urandom_range(0, ATTEMPT_MAX) : $urandom_range(0, 4));
         program_timing(first_ms, ceiling_ms, attempts, $urandom_range(0, 4) != 0);
         case ($urandom_range(0, 3))
            0: idle_pct = 0;
            1: idle_pct = 5;
            2: idle_pct = 25;
            default: idle_pct = 60;
         endcase
         repeat (per_phase) begin
            pick_session_event(fn, url_ok);
            send_event(fn, url_ok);
         end
      end
   endtask

   task automatic test_steady_stream();
      logic [2:0] fn;
      logic       url_ok;
      program_timing(2, 8, 3, 1'b1);
      idle_pct = 0;
      repeat (120) begin
         pick_session_event(fn, url_ok);
         send_event(fn, url_ok);
      end
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= (stall_left == 1);
      end else if (idle_pct != 0 && $urandom_range(0, 99) <= idle_pct / 3) begin
         stall_left <= $urandom_range(1, 18);
         rsp_ready <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            head_report = pending_reports.pop_front();
            if (rsp_link_state !== head_report.state)
               report_mismatch($sformatf("link_state got %0d want %0d",
                                         rsp_link_state, head_report.state));
            if (rsp_state_changed !== head_report.changed)
               report_mismatch($sformatf("state_changed got %0d want %0d",
                                         rsp_state_changed, head_report.changed));
            if (rsp_error_code !== head_report.err)
               report_mismatch($sformatf("error_code got %0d want %0d",
                                         rsp_error_code, head_report.err));
            if (rsp_open_request !== head_report.open)
               report_mismatch($sformatf("open_request got %0d want %0d",
                                         rsp_open_request, head_report.open));
            if (rsp_retry_wait_ms !== head_report.wait_ms)
               report_mismatch($sformatf("retry_wait_ms got %0d want %0d",
                                         rsp_retry_wait_ms, head_report.wait_ms));
            if (rsp_reconnect_count !== head_report.count)
               report_mismatch($sformatf("reconnect_count got %0d want %0d",
                                         rsp_reconnect_count, head_report.count));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("no request or response moved for %0d cycles", WATCHDOG_LIMIT);
         $display("reconnect_backoff_supervisor regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_default_backoff();
      test_connect_paths();
      test_retry_paths();
      test_delay_extremes();
      test_attempt_saturation();
      test_random_sessions(7, 90);
      test_steady_stream();
      drain_responses();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("reconnect_backoff_supervisor regression: pass");
      end else begin
         $display("reconnect_backoff_supervisor regression: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire

### files.f
+incdir+sv
sv/rbs_pkg.sv
sv/rbs_cfg.sv
sv/rbs_backoff.sv
sv/rbs_engine.sv
sv/reconnect_backoff_supervisor.sv
tb/sv/tb_reconnect_backoff_supervisor.sv
